### rtl/cts_pkg.sv
`timescale 1ns / 1ps
package cts_pkg;
   localparam int KEYWORD_MAX_LEN_DEF = 8;
   localparam int COUNT_BITS_DEF = 16;
   localparam int KW_NUM = 32;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [3:0] K_KEYWORD = 4'd0;
   localparam logic [3:0] K_IDENT = 4'd1;
   localparam logic [3:0] K_OPER = 4'd2;
   localparam logic [3:0] K_DELIM = 4'd3;
   localparam logic [3:0] K_CHAR = 4'd4;
   localparam logic [3:0] K_STRING = 4'd5;
   localparam logic [3:0] K_NUMBER = 4'd6;
   localparam logic [3:0] K_ERROR = 4'd7;
   localparam logic [3:0] K_END = 4'd8;

   typedef struct packed {
      logic [7:0] source_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [3:0]  token_kind;
      logic [15:0] line_number;
      logic [15:0] token_length;
      logic [5:0]  token_code;
      logic        last_of_run;
   } rsp_type;

   // The one or two scanner events of one byte, before the back end splits them onto the result channel.
   typedef struct packed {
      logic    two;
      rsp_type ev0;
      rsp_type ev1;
   } evpair_type;

   function automatic logic [63:0] kw_text(input logic [4:0] i);
      case (i)
         5'd0: kw_text = "auto";
         5'd1: kw_text = "switch";
         5'd2: kw_text = "union";
         5'd3: kw_text = "void";
         5'd4: kw_text = "double";
         5'd5: kw_text = "case";
         5'd6: kw_text = "const";
         5'd7: kw_text = "default";
         5'd8: kw_text = "int";
         5'd9: kw_text = "enum";
         5'd10: kw_text = "float";
         5'd11: kw_text = "goto";
         5'd12: kw_text = "struct";
         5'd13: kw_text = "register";
         5'd14: kw_text = "short";
         5'd15: kw_text = "sizeof";
         5'd16: kw_text = "break";
         5'd17: kw_text = "typedef";
         5'd18: kw_text = "unsigned";
         5'd19: kw_text = "volatile";
         5'd20: kw_text = "else";
         5'd21: kw_text = "char";
         5'd22: kw_text = "continue";
         5'd23: kw_text = "do";
         5'd24: kw_text = "static";
         5'd25: kw_text = "extern";
         5'd26: kw_text = "for";
         5'd27: kw_text = "if";
         5'd28: kw_text = "long";
         5'd29: kw_text = "return";
         5'd30: kw_text = "signed";
         default: kw_text = "while";
      endcase
   endfunction

   function automatic logic [3:0] kw_len(input logic [4:0] i);
      logic [63:0] t;
      logic [3:0]  n;
      t = kw_text(i);
      n = 4'd0;
      for (int b = 0; b < 8; b++)
         if (t[b*8 +: 8] != 8'd0) n = n + 4'd1;
      kw_len = n;
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      is_letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction
   function automatic logic is_digit(input logic [7:0] c);
      is_digit = c >= "0" && c <= "9";
   endfunction
   function automatic logic is_hex(input logic [7:0] c);
      is_hex = is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction
endpackage

### rtl/cts_if.sv
`timescale 1ns / 1ps
interface cts_req_if;
   logic             valid;
   logic             ready;
   cts_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface cts_rsp_if;
   logic             valid;
   logic             ready;
   cts_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### rtl/c_token_scanner_core.sv
`timescale 1ns / 1ps
// C token scanner. Feed source bytes on req (valid/ready); one byte is taken
// per cycle whenever the event queue has room. Each byte yields zero, one or
// two token events on rsp; last_of_run marks the final event of a byte. An
// item with end_of_input set yields one end event with the line count and
// returns the scanner to its start state.
// An event is registered in the event queue when its byte is taken and leaves on rsp from there.
// Throughput: one byte per cycle while the queue has room; a byte giving two events holds the
// result port for both of them in turn, and the four-entry event queue absorbs such bursts.
// When rsp stalls, the queue fills and req.ready drops; nothing is lost.
// Reset (synchronous) empties the queue, sets the line count to one and the
// automaton to its start state.
module c_token_scanner_core #(
   parameter int KEYWORD_MAX_LEN = cts_pkg::KEYWORD_MAX_LEN_DEF,
   parameter int COUNT_BITS = cts_pkg::COUNT_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   cts_req_if.sink   req,
   cts_rsp_if.source rsp
);
   logic                ev_valid, ev_ready;
   cts_pkg::evpair_type ev_item;

   cts_front #(.KEYWORD_MAX_LEN(KEYWORD_MAX_LEN), .COUNT_BITS(COUNT_BITS)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_item(req.payload), .in_ready(req.ready),
      .ev_valid(ev_valid), .ev_item(ev_item), .ev_ready(ev_ready));

   cts_back #(.DEPTH(cts_pkg::QUEUE_DEPTH)) u_back (
      .clock(clock), .reset(reset),
      .ev_valid(ev_valid), .ev_item(ev_item), .ev_ready(ev_ready),
      .out_valid(rsp.valid), .out_item(rsp.payload), .out_ready(rsp.ready));

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.payload.token_kind == cts_pkg::K_END |-> rsp.payload.last_of_run)
      else $error("end event not last");
   a_end_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.payload.token_kind == cts_pkg::K_END |-> rsp.payload.token_length == 16'd0)
      else $error("end event with length");
   a_no_ev_ready: assert property (@(posedge clock) disable iff (reset)
      ev_valid && !ev_ready |-> !req.ready)
      else $error("byte taken with full queue");
endmodule

### rtl/cts_front.sv
`timescale 1ns / 1ps
// Runs the automaton on one byte per cycle while ev_ready is high; a lookahead byte is rescanned in
// the same cycle from the start state, so up to two events leave per byte.
module cts_front #(
   parameter int KEYWORD_MAX_LEN = cts_pkg::KEYWORD_MAX_LEN_DEF,
   parameter int COUNT_BITS = cts_pkg::COUNT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  cts_pkg::req_type      in_item,
   output logic                  in_ready,
   output logic                  ev_valid,
   output cts_pkg::evpair_type   ev_item,
   input  logic                  ev_ready
);
   localparam int PW = $clog2(KEYWORD_MAX_LEN);
   localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
   localparam int KW_NUM_L = cts_pkg::KW_NUM;

   typedef struct packed {
      logic [5:0]            st;
      logic [COUNT_BITS-1:0] cnt;
      logic [COUNT_BITS-1:0] line;
      logic                  add;
      logic                  em;
      logic [3:0]            kind;
      logic [5:0]            code;
      logic                  again;
   } step_type;

   logic [5:0]            state_ff, state_in;
   logic [COUNT_BITS-1:0] count_ff, count_in, line_ff, line_in;
   logic [7:0]            prefix_ff [KEYWORD_MAX_LEN];

   assign in_ready = ev_ready;

   function automatic logic [15:0] sat16(input logic [COUNT_BITS-1:0] v);
      if (COUNT_BITS > 16 && (v >> 16) != '0) sat16 = 16'hFFFF;
      else sat16 = 16'(v);
   endfunction

   // keyword index of the current prefix, 6'h3F when none
   // keyword text is right-aligned: its last byte sits at the bottom of the word
   function automatic logic [5:0] kw_find(input logic [COUNT_BITS-1:0] n,
                                          input logic [8*KEYWORD_MAX_LEN-1:0] p);
      logic [5:0]  r;
      logic [63:0] t;
      logic [3:0]  l;
      logic        ok;
      r = 6'h3F;
      for (int i = KW_NUM_L - 1; i >= 0; i--) begin
         t = cts_pkg::kw_text(5'(i));
         l = cts_pkg::kw_len(5'(i));
         ok = n == COUNT_BITS'(l);
         for (int b = 0; b < 8; b++)
            if (b < int'(l) && p[b*8 +: 8] != t[(int'(l) - 1 - b) * 8 +: 8])
               ok = 1'b0;
         if (ok) r = 6'(i);
      end
      kw_find = r;
   endfunction

   logic [8*KEYWORD_MAX_LEN-1:0] pflat;
   always_comb begin
      for (int b = 0; b < KEYWORD_MAX_LEN; b++) pflat[b*8 +: 8] = prefix_ff[b];
   end

   function automatic step_type scan(input logic [5:0] s, input logic [COUNT_BITS-1:0] cnt,
                                     input logic [COUNT_BITS-1:0] ln, input logic [7:0] c,
                                     input logic [5:0] kwi);
      step_type r;
      logic [5:0] nx;
      logic ent, cl, la;
      logic [5:0] oc;
      r = '0;
      r.st = s; r.cnt = cnt; r.line = ln;
      nx = 6'd0; ent = 1'b0; cl = 1'b0; la = 1'b0; oc = 6'd0;
      case (s)
         6'd0: begin
            ent = 1'b1;
            if (c == "u") nx = 6'd31;
            else if (c == "U" || c == "L") nx = 6'd33;
            else if (cts_pkg::is_letter(c) || c == "_") nx = 6'd1;
            else if (cts_pkg::is_digit(c)) nx = 6'd2;
            else if (c == "<") nx = 6'd8;
            else if (c == ">") nx = 6'd10;
            else if (c == "=") nx = 6'd12;
            else if (c == "!") nx = 6'd13;
            else if (c == "&") nx = 6'd14;
            else if (c == "|") nx = 6'd15;
            else if (c == "+") nx = 6'd16;
            else if (c == "-") nx = 6'd17;
            else if (c == "*") nx = 6'd18;
            else if (c == "/") nx = 6'd19;
            else if (c == "%") nx = 6'd20;
            else if (c == "^") nx = 6'd21;
            else if (c == ".") nx = 6'd3;
            else if (c == 8'h27) nx = 6'd22;
            else if (c == "\"") nx = 6'd24;
            else begin
               ent = 1'b0;
               case (c)
                  "~": begin r.em = 1'b1; r.kind = cts_pkg::K_OPER; end
                  8'h0A: if (ln != CMAX) r.line = ln + 1'b1;
                  "@": begin r.add = 1'b1; r.em = 1'b1; r.kind = cts_pkg::K_ERROR; end
                  ";": begin r.em = 1'b1; r.kind = cts_pkg::K_DELIM; r.code = 6'd0; end
                  ",": begin r.em = 1'b1; r.kind = cts_pkg::K_DELIM; r.code = 6'd1; end
                  ":": begin r.em = 1'b1; r.kind = cts_pkg::K_DELIM; r.code = 6'd2; end
                  "?": begin r.em = 1'b1; r.kind = cts_pkg::K_DELIM; r.code = 6'd3; end
                  "[": begin r.em = 1'b1; r.kind = cts_pkg::K_DELIM; r.code = 6'd4; end
                  "]": begin r.em = 1'b1; r.kind = cts_pkg::K_DELIM; r.code = 6'd5; end
                  "(": begin r.em = 1'b1; r.kind = cts_pkg::K_DELIM; r.code = 6'd6; end
                  ")": begin r.em = 1'b1; r.kind = cts_pkg::K_DELIM; r.code = 6'd7; end
                  "{": begin r.em = 1'b1; r.kind = cts_pkg::K_DELIM; r.code = 6'd8; end
                  "}": begin r.em = 1'b1; r.kind = cts_pkg::K_DELIM; r.code = 6'd9; end
                  default: ;
               endcase
            end
         end
         6'd1: begin
            if (cts_pkg::is_letter(c) || cts_pkg::is_digit(c) || c == "_") begin
               ent = 1'b1; nx = 6'd1;
            end else begin
               r.em = 1'b1; r.again = 1'b1;
               if (kwi != 6'h3F) begin r.kind = cts_pkg::K_KEYWORD; r.code = kwi; end
               else r.kind = cts_pkg::K_IDENT;
            end
         end
         6'd2: begin
            if (cts_pkg::is_digit(c)) begin ent = 1'b1; nx = 6'd2; end
            else if (c == ".") begin ent = 1'b1; nx = 6'd3; end
            else if (c == "e" || c == "E") begin ent = 1'b1; nx = 6'd5; end
            else if (c == "x" || c == "X") begin ent = 1'b1; nx = 6'd29; end
            else if (c == "u" || c == "U" || c == "l" || c == "L") begin
               ent = 1'b1; nx = 6'd30;
            end else if (cts_pkg::is_letter(c)) begin
               r.add = 1'b1; r.em = 1'b1; r.kind = cts_pkg::K_ERROR;
            end else begin r.em = 1'b1; r.kind = cts_pkg::K_NUMBER; r.again = 1'b1; end
         end
         6'd3: begin
            if (cts_pkg::is_digit(c)) begin ent = 1'b1; nx = 6'd4; end
            else begin cl = 1'b1; la = 1'b1; oc = 6'd1; end
         end
         6'd4, 6'd7: begin
            if (cts_pkg::is_digit(c)) begin ent = 1'b1; nx = s; end
            else if (s == 6'd4 && (c == "e" || c == "E")) begin ent = 1'b1; nx = 6'd5; end
            else if (c == "f" || c == "F" || c == "l" || c == "L") begin
               r.add = 1'b1; r.em = 1'b1; r.kind = cts_pkg::K_NUMBER;
            end else begin r.em = 1'b1; r.kind = cts_pkg::K_NUMBER; r.again = 1'b1; end
         end
         6'd5: begin
            if (c == "+" || c == "-") begin ent = 1'b1; nx = 6'd6; end
            else if (cts_pkg::is_digit(c)) begin ent = 1'b1; nx = 6'd7; end
            else begin r.em = 1'b1; r.kind = cts_pkg::K_ERROR; r.again = 1'b1; end
         end
         6'd6: begin
            if (cts_pkg::is_digit(c)) begin ent = 1'b1; nx = 6'd7; end
            else begin r.em = 1'b1; r.kind = cts_pkg::K_ERROR; end
         end
         6'd8: begin
            if (c == "=") begin cl = 1'b1; oc = 6'd3; end
            else if (c == "<") begin ent = 1'b1; nx = 6'd9; end
            else begin cl = 1'b1; la = 1'b1; oc = 6'd2; end
         end
         6'd9: begin cl = 1'b1; la = c != "="; oc = (c == "=") ? 6'd5 : 6'd4; end
         6'd10: begin
            if (c == "=") begin cl = 1'b1; oc = 6'd7; end
            else if (c == ">") begin ent = 1'b1; nx = 6'd11; end
            else begin cl = 1'b1; la = 1'b1; oc = 6'd6; end
         end
         6'd11: begin cl = 1'b1; la = c != "="; oc = (c == "=") ? 6'd9 : 6'd8; end
         6'd12: begin cl = 1'b1; la = c != "="; oc = (c == "=") ? 6'd11 : 6'd10; end
         6'd13: begin cl = 1'b1; la = c != "="; oc = (c == "=") ? 6'd13 : 6'd12; end
         6'd14: begin
            cl = 1'b1;
            if (c == "&") oc = 6'd15;
            else if (c == "=") oc = 6'd16;
            else begin la = 1'b1; oc = 6'd14; end
         end
         6'd15: begin
            cl = 1'b1;
            if (c == "|") oc = 6'd18;
            else if (c == "=") oc = 6'd19;
            else begin la = 1'b1; oc = 6'd17; end
         end
         6'd16: begin
            cl = 1'b1;
            if (c == "+") oc = 6'd21;
            else if (c == "=") oc = 6'd22;
            else begin la = 1'b1; oc = 6'd20; end
         end
         6'd17: begin
            cl = 1'b1;
            if (c == "-") oc = 6'd24;
            else if (c == "=") oc = 6'd25;
            else if (c == ">") oc = 6'd26;
            else begin la = 1'b1; oc = 6'd23; end
         end
         6'd18: begin cl = 1'b1; la = c != "="; oc = (c == "=") ? 6'd28 : 6'd27; end
         6'd19: begin
            if (c == "=") begin cl = 1'b1; oc = 6'd30; end
            else if (c == "/") begin r.st = 6'd26; end
            else if (c == "*") begin r.st = 6'd27; end
            else begin cl = 1'b1; la = 1'b1; oc = 6'd29; end
         end
         6'd20: begin cl = 1'b1; la = c != "="; oc = (c == "=") ? 6'd32 : 6'd31; end
         6'd21: begin cl = 1'b1; la = c != "="; oc = (c == "=") ? 6'd34 : 6'd33; end
         6'd22, 6'd24: begin
            if ((s == 6'd22 && c == 8'h27) || (s == 6'd24 && c == "\"")) begin
               r.em = 1'b1;
               r.kind = (s == 6'd22) ? cts_pkg::K_CHAR : cts_pkg::K_STRING;
            end else if (c == 8'h5C) begin ent = 1'b1; nx = s + 6'd1; end
            else if (c == 8'h0A) begin
               r.em = 1'b1; r.kind = cts_pkg::K_ERROR; r.again = 1'b1;
            end else begin ent = 1'b1; nx = s; end
         end
         6'd23, 6'd25: begin
            if (c == "o" || c == "n" || c == "r" || c == "t" || c == "v" || c == "a" ||
                c == "b" || c == "f" || c == 8'h27 || c == "\"" || c == 8'h5C ||
                c == "?" || c == "0" || c == "1" || c == "x") begin
               ent = 1'b1; nx = s - 6'd1;
            end else begin r.em = 1'b1; r.kind = cts_pkg::K_ERROR; end
         end
         6'd26: begin
            if (c == 8'h0A) begin
               if (ln != CMAX) r.line = ln + 1'b1;
               r.st = 6'd0; r.cnt = '0;
            end
         end
         6'd27, 6'd28: begin
            if (s == 6'd28 && c == "/") begin r.st = 6'd0; r.cnt = '0; end
            else if (c == "*") r.st = 6'd28;
            else begin
               if (c == 8'h0A && ln != CMAX) r.line = ln + 1'b1;
               r.st = 6'd27;
            end
         end
         6'd29: begin
            if (cts_pkg::is_hex(c)) begin ent = 1'b1; nx = 6'd29; end
            else begin r.em = 1'b1; r.kind = cts_pkg::K_NUMBER; r.again = 1'b1; end
         end
         6'd30: begin
            if (c == "u" || c == "U" || c == "l" || c == "L") begin ent = 1'b1; nx = 6'd30; end
            else begin r.em = 1'b1; r.kind = cts_pkg::K_NUMBER; r.again = 1'b1; end
         end
         6'd31: begin
            ent = 1'b1;
            if (c == "\"") nx = 6'd24;
            else if (c == "8") nx = 6'd32;
            else if (c == 8'h27) nx = 6'd22;
            else nx = 6'd1;
         end
         6'd32: begin ent = 1'b1; nx = (c == "\"") ? 6'd24 : 6'd1; end
         6'd33: begin
            ent = 1'b1;
            if (c == "\"") nx = 6'd24;
            else if (c == 8'h27) nx = 6'd22;
            else nx = 6'd1;
         end
         default: begin r.st = 6'd0; r.cnt = '0; end
      endcase
      if (cl) begin
         r.em = 1'b1; r.kind = cts_pkg::K_OPER; r.code = oc; r.again = la;
      end
      if (ent) begin r.st = nx; r.add = 1'b1; end
      return r;
   endfunction

   step_type p1, p2;
   logic [COUNT_BITS-1:0] c1, c2;
   logic [5:0] kwi;
   logic [7:0] ch;
   logic fire;

   assign ch = in_item.source_byte;
   assign kwi = (count_ff > COUNT_BITS'(8)) ? 6'h3F : kw_find(count_ff, pflat);
   assign fire = in_valid && in_ready;

   always_comb begin
      p1 = scan(state_ff, count_ff, line_ff, ch, kwi);
      c1 = p1.cnt + ((p1.add && p1.cnt != CMAX) ? COUNT_BITS'(1) : '0);
      p2 = scan(6'd0, '0, p1.line, ch, 6'h3F);
      c2 = (p2.add) ? COUNT_BITS'(1) : '0;
      ev_item = '0;
      state_in = p1.st;
      count_in = c1;
      line_in = p1.line;
      ev_valid = 1'b0;
      if (in_item.end_of_input) begin
         ev_valid = in_valid;
         ev_item.ev0.token_kind = cts_pkg::K_END;
         ev_item.ev0.line_number = sat16(line_ff);
         ev_item.ev0.last_of_run = 1'b1;
         state_in = 6'd0; count_in = '0; line_in = COUNT_BITS'(1);
      end else begin
         ev_item.ev0.token_kind = p1.kind;
         ev_item.ev0.line_number = sat16(p1.line);
         ev_item.ev0.token_length = sat16(c1);
         ev_item.ev0.token_code = p1.code;
         ev_item.ev0.last_of_run = !(p1.again && p2.em);
         ev_item.ev1.token_kind = p2.kind;
         ev_item.ev1.line_number = sat16(p2.line);
         ev_item.ev1.token_length = sat16(c2);
         ev_item.ev1.token_code = p2.code;
         ev_item.ev1.last_of_run = 1'b1;
         if (p1.em) begin
            state_in = 6'd0; count_in = '0;
            ev_valid = in_valid;
            if (p1.again) begin
               ev_item.two = p2.em;
               state_in = p2.em ? 6'd0 : p2.st;
               count_in = p2.em ? '0 : c2;
               line_in = p2.line;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= 6'd0;
         count_ff <= '0;
         line_ff <= COUNT_BITS'(1);
      end else if (fire) begin
         state_ff <= state_in;
         count_ff <= count_in;
         line_ff <= line_in;
      end
   end

   // prefix write: first pass adds at old count, rescan adds at zero
   always_ff @(posedge clock) begin
      if (fire && !in_item.end_of_input) begin
         if (p1.em && p1.again && p2.add && !p2.em) prefix_ff[0] <= ch;
         else if (p1.add && count_ff < COUNT_BITS'(KEYWORD_MAX_LEN))
            prefix_ff[PW'(count_ff)] <= ch;
      end
   end
endmodule

### rtl/cts_back.sv
`timescale 1ns / 1ps
// Queue of event pairs, unpacked one item per cycle onto the result channel while out_ready is high.
module cts_back #(
   parameter int DEPTH = cts_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                ev_valid,
   input  cts_pkg::evpair_type ev_item,
   output logic                ev_ready,
   output logic                out_valid,
   output cts_pkg::rsp_type    out_item,
   input  logic                out_ready
);
   localparam int AW = $clog2(DEPTH);
   cts_pkg::evpair_type q_ff [DEPTH];
   logic [AW-1:0] wr_ff, rd_ff;
   logic [AW:0]   fill_ff;
   logic          half_ff;
   logic          push, pop;

   assign ev_ready = fill_ff != (AW+1)'(DEPTH);
   assign push = ev_valid && ev_ready;
   assign out_valid = fill_ff != '0;
   assign out_item = half_ff ? q_ff[rd_ff].ev1 : q_ff[rd_ff].ev0;
   // pop the pair after its last half leaves
   assign pop = out_valid && out_ready && (half_ff || !q_ff[rd_ff].two);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; fill_ff <= '0; half_ff <= 1'b0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         fill_ff <= fill_ff + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
         if (out_valid && out_ready) half_ff <= !pop;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= ev_item;
   end
endmodule
